/* design/wcsd_pkg.sv */
package wcsd_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int NUM_CMD     = 4;
  localparam int SCORE_W     = 13;
  localparam int ENTRY_W     = 12;
  localparam int OUT_SUM_W   = 16;
  localparam int CLASS_W     = 3;

  localparam logic [CLASS_W-1:0]       CLASS_NONSENSE = 3'd4;
  localparam logic signed [SCORE_W-1:0] LOG_FLOOR     = -13'sd3537;
  localparam logic [ENTRY_W-1:0]       FLOOR_MAG      = 12'd3537;
  localparam logic [ENTRY_W-1:0]       REFILL_MAG     = 12'd3584;
  localparam logic signed [OUT_SUM_W-1:0] THRESH_RESET = -16'sd8960;

  // Register index taken from the word address of the APB port.
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_ACC,
    ST_BEST,
    ST_DECIDE
  } step_t;

  typedef enum logic [1:0] {
    CD_ALWAYS,
    CD_IN_VALID,
    CD_MORE,
    CD_OUT_FREE
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  in_rdy;
    logic  write;
    logic  read;
    logic  acc;
    logic  best;
    logic  decide;
  } uword_t;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic write;
    logic read;
    logic acc;
    logic best;
    logic decide;
  } ctrl_t;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{cond: CD_ALWAYS, target: ST_IDLE, default: 1'b0};
    unique case (s)
      ST_IDLE: begin
        w.cond   = CD_IN_VALID;
        w.target = ST_WRITE;
        w.in_rdy = 1'b1;
      end
      ST_WRITE: begin
        w.target = ST_READ;
        w.write  = 1'b1;
      end
      ST_READ: begin
        w.target = ST_ACC;
        w.read   = 1'b1;
      end
      ST_ACC: begin
        w.cond   = CD_MORE;
        w.target = ST_READ;
        w.acc    = 1'b1;
      end
      ST_BEST: begin
        w.target = ST_DECIDE;
        w.best   = 1'b1;
      end
      ST_DECIDE: begin
        w.cond   = CD_OUT_FREE;
        w.target = ST_IDLE;
        w.decide = 1'b1;
      end
      default: begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // Clamp a log score into [floor, 0] and return its magnitude.
  function automatic logic [ENTRY_W-1:0] clamp_mag(input logic signed [SCORE_W-1:0] s,
                                                   input logic v);
    logic signed [SCORE_W-1:0] n;
    n = -s;
    if (!v) begin
      return FLOOR_MAG;
    end else if (s > 0) begin
      return '0;
    end else if (s < LOG_FLOOR) begin
      return FLOOR_MAG;
    end else begin
      return n[ENTRY_W-1:0];
    end
  endfunction

endpackage

/* design/wcsd_ram.sv */
module wcsd_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 5
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/wcsd_seq.sv */
module wcsd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            rows_more,
  input  logic            out_free,
  output wcsd_pkg::ctrl_t ctrl
);
  import wcsd_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uw = ucode(step);
    unique case (uw.cond)
      CD_ALWAYS:   step_next = uw.target;
      CD_IN_VALID: step_next = in_valid ? uw.target : step;
      CD_MORE:     step_next = rows_more ? uw.target : step_t'(step + 3'd1);
      CD_OUT_FREE: step_next = out_free ? uw.target : step;
      default:     step_next = ST_IDLE;
    endcase
    ctrl.in_ready = uw.in_rdy;
    ctrl.take     = uw.in_rdy & in_valid;
    ctrl.write    = uw.write;
    ctrl.read     = uw.read;
    ctrl.acc      = uw.acc;
    ctrl.best     = uw.best;
    ctrl.decide   = uw.decide & out_free;
  end

endmodule

/* design/windowed_command_score_detector_top.sv */
// Channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | score_* (5 x s13), frame_valid
// output   | out_valid / out_ready| best_class, best_sum (s16), detected
// config   | APB, pready high     | score threshold (s16) at byte address 0
//
// An item runs through the idle, write, read and accumulate steps, then best and
// decide: the ring is summed one row per registered read of the ring RAM, in a read and an accumulate step per row.
// Reset clears the row valid bits, so every row reads as -14 at once; the
// threshold resets to -35.0. A detection refills the ring the same way.
// The result register lets a new item enter while a result waits; an item
// holds in the decide step only while the previous result is still untaken.
module windowed_command_score_detector_top #(
  parameter int WINDOW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [12:0]   score_forward,
  input  logic signed [12:0]   score_backward,
  input  logic signed [12:0]   score_left,
  input  logic signed [12:0]   score_right,
  input  logic signed [12:0]   score_nonsense,
  input  logic                 frame_valid,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           best_class,
  output logic signed [15:0]   best_sum,
  output logic                 detected
);
  import wcsd_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int MAG_W = $clog2(3584 * WINDOW + 1);
  localparam int SUM_W = MAG_W + 1;
  localparam int CMP_W = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
  localparam int ROW_W = ENTRY_W * NUM_CLASSES;
  localparam logic signed [CMP_W-1:0] SAT_LO = CMP_W'(-32768);

  ctrl_t ctrl;
  logic  rows_more;
  logic  out_free;

  logic signed [OUT_SUM_W-1:0] thr;
  logic [ROW_W-1:0]  row_in;
  logic [ROW_W-1:0]  rdata;
  logic [IDX_W-1:0]  wslot;
  logic [WINDOW-1:0] row_ok;
  logic [CNT_W-1:0]  cnt;
  logic              rd_ok;
  logic [MAG_W-1:0]  acc [NUM_CLASSES];
  logic [MAG_W-1:0]  bm;
  logic [CLASS_W-1:0] bc;
  logic [MAG_W-1:0]  best_mag;
  logic [CLASS_W-1:0] best_cls;

  logic signed [CMP_W-1:0] thr_x;
  logic signed [CMP_W-1:0] best_s;
  logic signed [CMP_W-1:0] non_s;
  logic signed [CMP_W-1:0] rep_s;
  logic                    hit;
  logic signed [OUT_SUM_W-1:0] rep_sat;

  wcsd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .rows_more (rows_more),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  wcsd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ctrl.write),
    .waddr (wslot),
    .wdata (row_in),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign in_ready  = ctrl.in_ready;
  assign rows_more = (cnt != CNT_W'(WINDOW));
  assign out_free  = !out_valid || out_ready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_THRESHOLD) ? {{16{thr[15]}}, thr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      thr <= pwdata[15:0];
    end
  end

  // Capture the clamped row on accept.
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      row_in <= {clamp_mag(score_nonsense, frame_valid),
                 clamp_mag(score_right, frame_valid),
                 clamp_mag(score_left, frame_valid),
                 clamp_mag(score_backward, frame_valid),
                 clamp_mag(score_forward, frame_valid)};
    end
  end

  // Row valid bits and write slot; a cleared row reads as the refill value.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      wslot  <= '0;
    end else begin
      if (ctrl.write) begin
        row_ok[wslot] <= 1'b1;
        wslot <= (wslot == IDX_W'(WINDOW - 1)) ? '0 : wslot + 1'b1;
      end
      if (ctrl.decide && hit) begin
        row_ok <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.write) begin
      cnt <= '0;
    end else if (ctrl.read) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      rd_ok <= row_ok[cnt[IDX_W-1:0]];
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (ctrl.write) begin
        acc[c] <= '0;
      end else if (ctrl.acc) begin
        acc[c] <= acc[c] + MAG_W'(rd_ok ? rdata[c*ENTRY_W +: ENTRY_W] : REFILL_MAG);
      end
    end
  end

  // Largest sum is the smallest magnitude; strict compare keeps the lower class.
  always_comb begin
    bm = acc[0];
    bc = '0;
    for (int c = 1; c < NUM_CMD; c++) begin
      if (acc[c] < bm) begin
        bm = acc[c];
        bc = CLASS_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.best) begin
      best_mag <= bm;
      best_cls <= bc;
    end
  end

  always_comb begin
    thr_x   = CMP_W'(thr);
    best_s  = -$signed(CMP_W'(best_mag));
    non_s   = -$signed(CMP_W'(acc[NUM_CLASSES-1]));
    hit     = (best_s > thr_x) && (acc[NUM_CLASSES-1] != '0);
    rep_s   = hit ? best_s : non_s;
    rep_sat = (rep_s < SAT_LO) ? -16'sd32768 : rep_s[OUT_SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.decide) begin
      best_class <= hit ? best_cls : CLASS_NONSENSE;
      best_sum   <= rep_sat;
      detected   <= hit;
    end
  end

  a_take_writes: assert property (@(posedge clk) disable iff (rst)
    ctrl.take |=> ctrl.write)
    else $error("accepted item not written to ring");

  a_decide_loads: assert property (@(posedge clk) disable iff (rst)
    ctrl.decide |=> out_valid)
    else $error("decision did not load result register");

  a_det_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && detected |-> best_class != CLASS_NONSENSE)
    else $error("detection reports nonsense class");

  a_miss_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && !detected |-> best_class == CLASS_NONSENSE)
    else $error("miss reports a command class");

  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    ctrl.acc |-> cnt != '0)
    else $error("accumulate without a row read");

endmodule

/* dv/wcsd_checker.sv */
module wcsd_checker #(
  parameter int WINDOW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic [31:0]          prdata,
  input  logic                 pready,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [12:0]   score_forward,
  input  logic signed [12:0]   score_backward,
  input  logic signed [12:0]   score_left,
  input  logic signed [12:0]   score_right,
  input  logic signed [12:0]   score_nonsense,
  input  logic                 frame_valid,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           best_class,
  input  logic signed [15:0]   best_sum,
  input  logic                 detected,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import wcsd_pkg::*;

  localparam int FLOOR_Q8        = -3537;
  localparam int REFILL_Q8       = -3584;
  localparam int THRESH_RESET_Q8 = -8960;
  localparam logic [2:0] THRESH_ADDR = {REG_THRESHOLD, 2'b00};

  typedef struct packed {
    logic [CLASS_W-1:0]          cls;
    logic signed [OUT_SUM_W-1:0] sum;
    logic                        det;
  } detection_t;

  int         window_scores [WINDOW][NUM_CLASSES];
  int         next_row;
  int         threshold_q8;
  detection_t expected_q [$];

  initial fail_count = 0;

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void refill_window();
    for (int r = 0; r < WINDOW; r++)
      for (int c = 0; c < NUM_CLASSES; c++)
        window_scores[r][c] = REFILL_Q8;
  endfunction

  function automatic int clamp_score(input logic signed [SCORE_W-1:0] s, input logic live);
    int v;
    v = int'(s);
    if (v > 0) v = 0;
    if (v < FLOOR_Q8) v = FLOOR_Q8;
    if (!live) v = FLOOR_Q8;
    return v;
  endfunction

  function automatic logic signed [OUT_SUM_W-1:0] saturate_sum(input int s);
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return OUT_SUM_W'(s);
  endfunction

  // Write the frame into the window, sum each class, pick the command and decide the hit (a hit refills).
  function automatic detection_t score_frame(input logic [NUM_CLASSES-1:0][SCORE_W-1:0] frame,
                                             input logic live);
    int         sums [NUM_CLASSES];
    int         top_sum;
    int         top_cls;
    detection_t d;
    for (int c = 0; c < NUM_CLASSES; c++)
      window_scores[next_row][c] = clamp_score($signed(frame[c]), live);
    next_row = (next_row + 1) % WINDOW;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      sums[c] = 0;
      for (int r = 0; r < WINDOW; r++)
        sums[c] += window_scores[r][c];
    end
    top_sum = sums[0];
    top_cls = 0;
    // strict compare: ties go to the lower class
    for (int c = 1; c < NUM_CMD; c++) begin
      if (sums[c] > top_sum) begin
        top_sum = sums[c];
        top_cls = c;
      end
    end
    if (top_sum > threshold_q8 && sums[CLASS_NONSENSE] < 0) begin
      refill_window();
      d.cls = CLASS_W'(top_cls);
      d.sum = saturate_sum(top_sum);
      d.det = 1'b1;
    end else begin
      d.cls = CLASS_NONSENSE;
      d.sum = saturate_sum(sums[CLASS_NONSENSE]);
      d.det = 1'b0;
    end
    return d;
  endfunction

  always @(posedge clk) begin
    detection_t want;
    if (rst) begin
      refill_window();
      next_row = 0;
      threshold_q8 = THRESH_RESET_Q8;
      expected_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == THRESH_ADDR) threshold_q8 = int'($signed(pwdata[15:0]));
        end else if (int'($signed(prdata[15:0])) != threshold_q8) begin
          report($sformatf("threshold read %0d, expected %0d",
                           $signed(prdata[15:0]), threshold_q8));
        end
      end
      // pop before push: a result never belongs to the item taken on the same edge
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("result class %0d sum %0d with no item pending",
                           best_class, best_sum));
        end else begin
          want = expected_q.pop_front();
          if (best_class !== want.cls)
            report($sformatf("best_class %0d, expected %0d", best_class, want.cls));
          if (best_sum !== want.sum)
            report($sformatf("best_sum %0d, expected %0d", best_sum, want.sum));
          if (detected !== want.det)
            report($sformatf("detected %0b, expected %0b", detected, want.det));
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(score_frame({score_nonsense, score_right, score_left,
                                          score_backward, score_forward}, frame_valid));
    end
    pending <= expected_q.size();
  end

endmodule

/* dv/tb_windowed_command_score_detector_top.sv */
module tb_windowed_command_score_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wcsd_pkg::*;

  localparam int WINDOW = 5;
  localparam logic [2:0] THRESH_ADDR = {REG_THRESHOLD, 2'b00};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [12:0] score_forward = '0;
  logic signed [12:0] score_backward = '0;
  logic signed [12:0] score_left = '0;
  logic signed [12:0] score_right = '0;
  logic signed [12:0] score_nonsense = '0;
  logic               frame_valid = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         best_class;
  logic signed [15:0] best_sum;
  logic               detected;
  int                 fail_count;
  int                 pending;
  bit                 steady = 1'b0;

  always #5 clk = ~clk;

  windowed_command_score_detector_top #(.WINDOW(WINDOW)) u_top (.*);

  wcsd_checker #(.WINDOW(WINDOW)) u_chk (.*);

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 17);

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_frame(input int f, input int b, input int l, input int r, input int n,
                            input bit live);
    if (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    score_forward  <= 13'(f);
    score_backward <= 13'(b);
    score_left     <= 13'(l);
    score_right    <= 13'(r);
    score_nonsense <= 13'(n);
    frame_valid    <= live;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off new items until every pending result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Leaves psel high so back-to-back transfers need no idle state between them.
  task automatic apb_access(input bit wr, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= THRESH_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_threshold(input int value);
    settle();
    apb_access(1'b1, value);
    apb_access(1'b0, 0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int sc [NUM_CLASSES];
    int cls, partner, len, roll, sent;
    bit live, tie;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset value readback
    apb_access(1'b0, 0);
    psel    <= 1'b0;
    penable <= 1'b0;

    // field extremes, clamping, invalid frame, exact floor
    send_frame(0, 0, 0, 0, 0, 1'b1);
    send_frame(-3584, -3584, -3584, -3584, -3584, 1'b1);
    send_frame(4095, 4095, 4095, 4095, 4095, 1'b1);
    send_frame(-4096, -4096, -4096, -4096, -4096, 1'b1);
    send_frame(0, 0, 0, 0, 0, 1'b0);
    send_frame(-3537, -3538, -3536, -1, -2, 1'b1);
    // four frames with equal command scores and a floored nonsense score
    repeat (4) send_frame(0, 0, 0, 0, -3584, 1'b1);

    set_threshold(-17920);
    send_frame(-3584, 0, -3584, -3584, -5, 1'b1);
    send_frame(-3584, -3584, 0, -3584, -5, 1'b1);
    send_frame(-3584, -3584, -3584, 0, -5, 1'b1);

    // window refilled: only the full window of floored commands clears this,
    // and a zero nonsense sum must still block it
    set_threshold(-17700);
    repeat (5) send_frame(-4096, -4096, -4096, -4096, 0, 1'b1);
    send_frame(-4096, -4096, -4096, -4096, -1, 1'b1);

    set_threshold(0);
    repeat (2) send_frame(0, 0, 0, 0, 0, 1'b1);

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_threshold(-17920);
        1: set_threshold(0);
        2: set_threshold(-8960);
        default: set_threshold(-int'($urandom_range(2000, 16000)));
      endcase
      steady = (phase == 3);
      sent = 0;
      while (sent < 100) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          // burst of frames favoring one command
          cls = $urandom_range(0, NUM_CMD - 1);
          partner = (cls + 1 + $urandom_range(0, NUM_CMD - 2)) % NUM_CMD;
          tie = ($urandom_range(9) == 0);
          len = $urandom_range(3, 6);
          for (int k = 0; k < len; k++) begin
            for (int c = 0; c < NUM_CMD; c++)
              sc[c] = -int'($urandom_range(1200, 3584));
            sc[cls] = -int'($urandom_range(0, 700));
            if (tie) sc[partner] = sc[cls];
            sc[CLASS_NONSENSE] = -int'($urandom_range(100, 3584));
            live = ($urandom_range(19) != 0);
            send_frame(sc[0], sc[1], sc[2], sc[3], sc[4], live);
          end
          sent += len;
        end else if (roll < 90) begin
          for (int c = 0; c < NUM_CLASSES; c++)
            sc[c] = -int'($urandom_range(0, 3584));
          send_frame(sc[0], sc[1], sc[2], sc[3], sc[4], 1'($urandom_range(1)));
          sent++;
        end else begin
          // any 13-bit value, positive scores included
          for (int c = 0; c < NUM_CLASSES; c++)
            sc[c] = int'($signed(13'($urandom)));
          send_frame(sc[0], sc[1], sc[2], sc[3], sc[4], 1'($urandom_range(1)));
          sent++;
        end
      end
    end
    steady = 1'b0;

    settle();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/wcsd_pkg.sv
design/wcsd_ram.sv
design/wcsd_seq.sv
design/windowed_command_score_detector_top.sv
dv/wcsd_checker.sv
dv/tb_windowed_command_score_detector_top.sv
